### design/uart_16550_register_block_defines.svh
// Assertion macros shared by the UART register block.
// Depends on nothing; included by the top level only.
`ifndef UART_16550_REGISTER_BLOCK_DEFINES_SVH
`define UART_16550_REGISTER_BLOCK_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define U16550_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u16550 same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define U16550_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u16550 next-cycle check failed");

`endif

### design/u16550_pkg.sv
// Types, codes, reset values and helper functions of the UART register block.
// Depends on nothing; used by the core, output buffer and top level.
package u16550_pkg;

  // Item opcodes.
  localparam logic [2:0] OP_READ    = 3'd0;
  localparam logic [2:0] OP_WRITE   = 3'd1;
  localparam logic [2:0] OP_RX_BYTE = 3'd2;
  localparam logic [2:0] OP_CTS     = 3'd3;
  localparam logic [2:0] OP_DSR     = 3'd4;

  // Register offsets in the 16550 layout.
  localparam logic [2:0] OFF_RBR = 3'd0;
  localparam logic [2:0] OFF_IER = 3'd1;
  localparam logic [2:0] OFF_IIR = 3'd2;
  localparam logic [2:0] OFF_LCR = 3'd3;
  localparam logic [2:0] OFF_MCR = 3'd4;
  localparam logic [2:0] OFF_LSR = 3'd5;
  localparam logic [2:0] OFF_MSR = 3'd6;
  localparam logic [2:0] OFF_SCR = 3'd7;

  // Interrupt identification codes.
  localparam logic [7:0] IIR_FIFO_BITS = 8'hC0;
  localparam logic [7:0] IIR_LINE      = 8'h06;
  localparam logic [7:0] IIR_DATA      = 8'h04;
  localparam logic [7:0] IIR_THRE      = 8'h02;
  localparam logic [7:0] IIR_MODEM     = 8'h00;

  // Reset values.
  localparam logic [7:0]  IER_RESET  = 8'h04;
  localparam logic [7:0]  LCR_RESET  = 8'h03;
  localparam logic [7:0]  LSR_RESET  = 8'h60;
  localparam logic [15:0] DIV_RESET  = 16'h000C;
  localparam logic [1:0]  TRIG_RESET = 2'd0;

  // Masks.
  localparam logic [7:0] LSR_ERR_MASK   = 8'h1E;
  localparam logic [7:0] MSR_DELTA_MASK = 8'h0F;
  localparam logic [7:0] MCR_WR_MASK    = 8'hE3;

  typedef struct packed {
    logic [7:0] read_data;
    logic       access_error;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       dtr_level;
    logic       rts_level;
    logic       irq;
  } result_t;

  function automatic logic [3:0] trig_level(input logic [1:0] code);
    logic [3:0] lvl;
    unique case (code)
      2'd0: lvl = 4'd1;
      2'd1: lvl = 4'd4;
      2'd2: lvl = 4'd8;
      2'd3: lvl = 4'd14;
      default: lvl = 4'd1;
    endcase
    return lvl;
  endfunction

  // rx_ok is true when the FIFO is off or filled to the trigger level.
  function automatic logic [7:0] ident(input logic [7:0] ier, input logic [7:0] lsr,
                                       input logic [7:0] msr, input logic rx_ok);
    logic [7:0] v;
    priority if (ier[2] && ((lsr & LSR_ERR_MASK) != 8'h00)) begin
      v = IIR_FIFO_BITS | IIR_LINE | 8'h01;
    end else if (ier[0] && lsr[0] && rx_ok) begin
      v = IIR_FIFO_BITS | IIR_DATA | 8'h01;
    end else if (ier[1] && lsr[5]) begin
      v = IIR_FIFO_BITS | IIR_THRE | 8'h01;
    end else if (ier[3] && ((msr & MSR_DELTA_MASK) != 8'h00)) begin
      v = IIR_FIFO_BITS | IIR_MODEM | 8'h01;
    end else begin
      v = IIR_FIFO_BITS;
    end
    return v;
  endfunction

endpackage

### design/u16550_rxq.sv
// Receive queue memory: one write port, one registered read port with
// write-to-read forwarding. Depends on nothing.
module u16550_rxq #(
  parameter int RX_FIFO_DEPTH = 16,
  localparam int AW = $clog2(RX_FIFO_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [RX_FIFO_DEPTH];
  logic [7:0] mem_q;
  logic [7:0] fwd_data;
  logic       fwd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q    <= mem[rd_addr];
    fwd_data <= wr_data;
  end

  // A write to the entry being read in the same cycle wins over the old data.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_hit ? fwd_data : mem_q;

endmodule

### design/u16550_core.sv
// Register state and per-beat update logic of the UART register block.
// Depends on u16550_pkg; drives the receive queue memory.
module u16550_core #(
  parameter int RX_FIFO_DEPTH = 16,
  localparam int AW = $clog2(RX_FIFO_DEPTH),
  localparam int CW = $clog2(RX_FIFO_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [2:0]          opcode,
  input  logic [2:0]          reg_offset,
  input  logic [7:0]          byte_in,
  input  logic                line_level,
  input  logic [7:0]          rxq_rd_data,
  output logic                rxq_wr_en,
  output logic [AW-1:0]       rxq_wr_addr,
  output logic [7:0]          rxq_wr_data,
  output logic [AW-1:0]       rxq_rd_addr,
  output logic [CW-1:0]       rx_fill,
  output u16550_pkg::result_t result
);

  logic [7:0]    rx_holding, rx_holding_next;
  logic [7:0]    int_enable, int_enable_next;
  logic          fifo_on, fifo_on_next;
  logic [1:0]    trig_code, trig_code_next;
  logic [7:0]    line_control, line_control_next;
  logic [7:0]    modem_control, modem_control_next;
  logic [7:0]    line_status, line_status_next;
  logic [7:0]    modem_status, modem_status_next;
  logic [7:0]    scratch_reg, scratch_reg_next;
  logic [15:0]   baud_divisor, baud_divisor_next;
  logic [AW-1:0] rx_head, rx_head_next;
  logic [CW-1:0] rx_count, rx_count_next;

  logic          dlab;
  logic          rx_ok_cur, rx_ok_next;
  logic [CW:0]   pos_sum, pos_wrap;
  logic [7:0]    ident_next;

  function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
    return (i == AW'(RX_FIFO_DEPTH - 1)) ? '0 : i + AW'(1);
  endfunction

  assign dlab = line_control[7];
  assign rx_ok_cur = !fifo_on ||
                     ((CW+4)'(rx_count) >= (CW+4)'(u16550_pkg::trig_level(trig_code)));
  assign rx_ok_next = !fifo_on_next ||
                      ((CW+4)'(rx_count_next) >=
                       (CW+4)'(u16550_pkg::trig_level(trig_code_next)));

  // Tail position of the queue, wrapped into the depth.
  always_comb begin
    pos_sum = (CW+1)'(rx_head) + (CW+1)'(rx_count);
    if (pos_sum >= (CW+1)'(RX_FIFO_DEPTH)) begin
      pos_wrap = pos_sum - (CW+1)'(RX_FIFO_DEPTH);
    end else begin
      pos_wrap = pos_sum;
    end
  end

  always_comb begin
    rx_holding_next    = rx_holding;
    int_enable_next    = int_enable;
    fifo_on_next       = fifo_on;
    trig_code_next     = trig_code;
    line_control_next  = line_control;
    modem_control_next = modem_control;
    line_status_next   = line_status;
    modem_status_next  = modem_status;
    scratch_reg_next   = scratch_reg;
    baud_divisor_next  = baud_divisor;
    rx_head_next       = rx_head;
    rx_count_next      = rx_count;
    rxq_wr_en          = 1'b0;
    rxq_wr_addr        = AW'(pos_wrap);
    rxq_wr_data        = byte_in;
    result             = '0;

    if (accept) begin
      unique case (opcode)
        u16550_pkg::OP_READ: begin
          unique case (reg_offset)
            u16550_pkg::OFF_RBR: begin
              if (dlab) begin
                result.read_data = baud_divisor[7:0];
              end else begin
                result.read_data = rx_holding;
                // With two or more queued bytes the next one comes from the
                // prefetched read of entry head+1.
                if (fifo_on && (rx_count > CW'(1))) begin
                  rx_head_next    = next_idx(rx_head);
                  rx_count_next   = rx_count - CW'(1);
                  rx_holding_next = rxq_rd_data;
                end else begin
                  if (fifo_on && (rx_count == CW'(1))) begin
                    rx_head_next  = next_idx(rx_head);
                    rx_count_next = '0;
                  end
                  line_status_next[0] = 1'b0;
                end
              end
            end
            u16550_pkg::OFF_IER: begin
              result.read_data = dlab ? baud_divisor[15:8] : int_enable;
            end
            u16550_pkg::OFF_IIR: begin
              result.read_data = u16550_pkg::ident(int_enable, line_status,
                                                   modem_status, rx_ok_cur);
            end
            u16550_pkg::OFF_LCR: result.read_data = line_control;
            u16550_pkg::OFF_MCR: result.read_data = modem_control;
            u16550_pkg::OFF_LSR: begin
              result.read_data = line_status;
              line_status_next = line_status & ~u16550_pkg::LSR_ERR_MASK;
            end
            u16550_pkg::OFF_MSR: begin
              result.read_data  = modem_status;
              modem_status_next = modem_status & ~u16550_pkg::MSR_DELTA_MASK;
            end
            u16550_pkg::OFF_SCR: result.read_data = scratch_reg;
            default: ;
          endcase
        end
        u16550_pkg::OP_WRITE: begin
          unique case (reg_offset)
            u16550_pkg::OFF_RBR: begin
              if (dlab) begin
                baud_divisor_next[7:0] = byte_in;
              end else begin
                result.tx_valid = 1'b1;
                result.tx_byte  = byte_in;
              end
            end
            u16550_pkg::OFF_IER: begin
              if (dlab) begin
                baud_divisor_next[15:8] = byte_in;
              end else begin
                int_enable_next = byte_in;
              end
            end
            u16550_pkg::OFF_IIR: begin
              fifo_on_next   = byte_in[0];
              trig_code_next = byte_in[7:6];
              if (byte_in[1]) begin
                rx_count_next = '0;
                rx_head_next  = '0;
              end
            end
            u16550_pkg::OFF_LCR: line_control_next = byte_in;
            u16550_pkg::OFF_MCR: modem_control_next = byte_in & u16550_pkg::MCR_WR_MASK;
            u16550_pkg::OFF_LSR: result.access_error = 1'b1;
            u16550_pkg::OFF_MSR: result.access_error = 1'b1;
            u16550_pkg::OFF_SCR: scratch_reg_next = byte_in;
            default: ;
          endcase
        end
        u16550_pkg::OP_RX_BYTE: begin
          if (fifo_on) begin
            if (rx_count == CW'(RX_FIFO_DEPTH)) begin
              line_status_next[1] = 1'b1;
            end else begin
              rxq_wr_en = 1'b1;
              if (rx_count == '0) begin
                rx_holding_next = byte_in;
              end
              rx_count_next       = rx_count + CW'(1);
              line_status_next[0] = 1'b1;
            end
          end else if (line_status[0]) begin
            line_status_next[1] = 1'b1;
          end else begin
            rx_holding_next     = byte_in;
            line_status_next[0] = 1'b1;
          end
        end
        u16550_pkg::OP_CTS: begin
          if (modem_status[4] != line_level) begin
            modem_status_next[0] = 1'b1;
          end
          modem_status_next[4] = line_level;
        end
        u16550_pkg::OP_DSR: begin
          if (modem_status[5] != line_level) begin
            modem_status_next[1] = 1'b1;
          end
          modem_status_next[5] = line_level;
        end
        default: ;
      endcase
    end

    ident_next       = u16550_pkg::ident(int_enable_next, line_status_next,
                                         modem_status_next, rx_ok_next);
    result.irq       = ident_next[0];
    result.dtr_level = modem_control_next[0];
    result.rts_level = modem_control_next[1];
  end

  // Keep entry head+1 prefetched so a pop finds it in the next cycle.
  assign rxq_rd_addr = next_idx(rx_head_next);
  assign rx_fill     = rx_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_holding    <= 8'h00;
      int_enable    <= u16550_pkg::IER_RESET;
      fifo_on       <= 1'b0;
      trig_code     <= u16550_pkg::TRIG_RESET;
      line_control  <= u16550_pkg::LCR_RESET;
      modem_control <= 8'h00;
      line_status   <= u16550_pkg::LSR_RESET;
      modem_status  <= 8'h00;
      scratch_reg   <= 8'h00;
      baud_divisor  <= u16550_pkg::DIV_RESET;
      rx_head       <= '0;
      rx_count      <= '0;
    end else begin
      rx_holding    <= rx_holding_next;
      int_enable    <= int_enable_next;
      fifo_on       <= fifo_on_next;
      trig_code     <= trig_code_next;
      line_control  <= line_control_next;
      modem_control <= modem_control_next;
      line_status   <= line_status_next;
      modem_status  <= modem_status_next;
      scratch_reg   <= scratch_reg_next;
      baud_divisor  <= baud_divisor_next;
      rx_head       <= rx_head_next;
      rx_count      <= rx_count_next;
    end
  end

endmodule

### design/u16550_outbuf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on u16550_pkg for the result struct.
module u16550_outbuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  u16550_pkg::result_t push_data,
  output logic                push_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output u16550_pkg::result_t out_data
);

  u16550_pkg::result_t skid_data;
  logic                skid_valid;
  logic                pop;

  assign pop        = out_valid && out_ready;
  assign push_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule

### design/uart_16550_register_block.sv
// Top level of the 16550-style UART register block.
// Depends on u16550_pkg, u16550_rxq, u16550_core, u16550_outbuf and the defines header.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_ready  opcode, reg_offset, byte_in, line_level
//   out      output     out_valid/out_ready  read_data, access_error, tx_valid,
//                                            tx_byte, dtr_level, rts_level, irq
//
// One item is accepted per cycle while in_ready is high; its result is registered.
// The receive queue memory is read every cycle at entry head+1, so a pop never waits.
// The two-entry output buffer takes items after out_ready drops until its skid fills.
// Reset is synchronous; the queue memory needs no clearing since only written
// entries are ever used.
`include "uart_16550_register_block_defines.svh"

module uart_16550_register_block #(
  parameter int RX_FIFO_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] opcode,
  input  logic [2:0] reg_offset,
  input  logic [7:0] byte_in,
  input  logic       line_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       access_error,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic       dtr_level,
  output logic       rts_level,
  output logic       irq
);

  localparam int AW = $clog2(RX_FIFO_DEPTH);
  localparam int CW = $clog2(RX_FIFO_DEPTH + 1);

  logic                accept;
  logic                rxq_wr_en;
  logic [AW-1:0]       rxq_wr_addr;
  logic [7:0]          rxq_wr_data;
  logic [AW-1:0]       rxq_rd_addr;
  logic [7:0]          rxq_rd_data;
  logic [CW-1:0]       rx_fill;
  u16550_pkg::result_t core_result;
  u16550_pkg::result_t out_data;

  assign accept = in_valid && in_ready;

  u16550_rxq #(.RX_FIFO_DEPTH(RX_FIFO_DEPTH)) u_rxq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rxq_wr_en),
    .wr_addr (rxq_wr_addr),
    .wr_data (rxq_wr_data),
    .rd_addr (rxq_rd_addr),
    .rd_data (rxq_rd_data)
  );

  u16550_core #(.RX_FIFO_DEPTH(RX_FIFO_DEPTH)) u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .opcode      (opcode),
    .reg_offset  (reg_offset),
    .byte_in     (byte_in),
    .line_level  (line_level),
    .rxq_rd_data (rxq_rd_data),
    .rxq_wr_en   (rxq_wr_en),
    .rxq_wr_addr (rxq_wr_addr),
    .rxq_wr_data (rxq_wr_data),
    .rxq_rd_addr (rxq_rd_addr),
    .rx_fill     (rx_fill),
    .result      (core_result)
  );

  u16550_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (core_result),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign read_data    = out_data.read_data;
  assign access_error = out_data.access_error;
  assign tx_valid     = out_data.tx_valid;
  assign tx_byte      = out_data.tx_byte;
  assign dtr_level    = out_data.dtr_level;
  assign rts_level    = out_data.rts_level;
  assign irq          = out_data.irq;

  `U16550_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, rx_fill <= CW'(RX_FIFO_DEPTH))
  `U16550_ASSERT_NOW(a_write_has_room, clk, rst, rxq_wr_en, rx_fill < CW'(RX_FIFO_DEPTH))
  `U16550_ASSERT_NEXT(a_full_holds, clk, rst, !in_ready && !out_ready, !in_ready)

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the 16550-style UART register block.
// Depends on u16550_pkg and uart_16550_register_block; a scoreboard class predicts each beat.
module tb;

  localparam int         RXQ_DEPTH   = 16;
  localparam int         ITEM_TARGET = 1300;
  localparam logic [7:0] IIR_PENDING = 8'h01;
  // Opcodes outside the defined set, which must leave the state alone.
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  class uart_reg_scoreboard;
    u16550_pkg::result_t due_results[$];
    int unsigned         errors;
    logic [7:0]          rx_hold, ier, iir, lcr, mcr, lsr, msr, scr;
    logic                fifo_en;
    int unsigned         trig, head, count;
    logic [15:0]         divisor;
    logic [7:0]          rxq[RXQ_DEPTH];

    function new();
      errors  = 0;
      rx_hold = 8'h00;
      ier     = u16550_pkg::IER_RESET;
      iir     = u16550_pkg::IIR_FIFO_BITS;
      lcr     = u16550_pkg::LCR_RESET;
      mcr     = 8'h00;
      lsr     = u16550_pkg::LSR_RESET;
      msr     = 8'h00;
      scr     = 8'h00;
      fifo_en = 1'b0;
      trig    = 1;
      head    = 0;
      count   = 0;
      divisor = u16550_pkg::DIV_RESET;
      foreach (rxq[i]) rxq[i] = 8'h00;
    endfunction

    // Applies one accepted input beat to the register state and queues its result.
    function void add_input(logic [2:0] op, logic [2:0] off, logic [7:0] data, logic lvl);
      u16550_pkg::result_t r;
      logic                dlab;
      int unsigned         pos;
      r    = '0;
      dlab = lcr[7];
      case (op)
        u16550_pkg::OP_READ: begin
          case (off)
            u16550_pkg::OFF_RBR: if (dlab) r.read_data = divisor[7:0];
            else begin
              r.read_data = rx_hold;
              if (fifo_en && count > 1) begin
                head    = (head + 1) % RXQ_DEPTH;
                count   = count - 1;
                rx_hold = rxq[head];
              end else begin
                if (fifo_en && count == 1) begin
                  head  = (head + 1) % RXQ_DEPTH;
                  count = 0;
                end
                lsr[0] = 1'b0;
              end
            end
            u16550_pkg::OFF_IER: r.read_data = dlab ? divisor[15:8] : ier;
            u16550_pkg::OFF_IIR: r.read_data = iir;
            u16550_pkg::OFF_LCR: r.read_data = lcr;
            u16550_pkg::OFF_MCR: r.read_data = mcr;
            u16550_pkg::OFF_LSR: begin
              r.read_data = lsr;
              lsr = lsr & ~u16550_pkg::LSR_ERR_MASK;
            end
            u16550_pkg::OFF_MSR: begin
              r.read_data = msr;
              msr = msr & ~u16550_pkg::MSR_DELTA_MASK;
            end
            default: r.read_data = scr;
          endcase
        end
        u16550_pkg::OP_WRITE: begin
          case (off)
            u16550_pkg::OFF_RBR: if (dlab) divisor[7:0] = data;
            else begin
              r.tx_valid = 1'b1;
              r.tx_byte  = data;
            end
            u16550_pkg::OFF_IER: if (dlab) divisor[15:8] = data;
            else ier = data;
            u16550_pkg::OFF_IIR: begin
              fifo_en = data[0];
              if (data[1]) begin
                count = 0;
                head  = 0;
              end
              case (data[7:6])
                2'd0:    trig = 1;
                2'd1:    trig = 4;
                2'd2:    trig = 8;
                default: trig = 14;
              endcase
            end
            u16550_pkg::OFF_LCR: lcr = data;
            u16550_pkg::OFF_MCR: mcr = data & u16550_pkg::MCR_WR_MASK;
            u16550_pkg::OFF_LSR, u16550_pkg::OFF_MSR: r.access_error = 1'b1;
            default: scr = data;
          endcase
        end
        u16550_pkg::OP_RX_BYTE: begin
          if (fifo_en) begin
            if (count >= RXQ_DEPTH) lsr[1] = 1'b1;
            else begin
              pos      = (head + count) % RXQ_DEPTH;
              rxq[pos] = data;
              if (count == 0) rx_hold = data;
              count  = count + 1;
              lsr[0] = 1'b1;
            end
          end else if (lsr[0]) begin
            lsr[1] = 1'b1;
          end else begin
            rx_hold = data;
            lsr[0]  = 1'b1;
          end
        end
        u16550_pkg::OP_CTS: begin
          if (msr[4] != lvl) msr[0] = 1'b1;
          msr[4] = lvl;
        end
        u16550_pkg::OP_DSR: begin
          if (msr[5] != lvl) msr[1] = 1'b1;
          msr[5] = lvl;
        end
        default: ;
      endcase

      // Interrupt priority: line error, data available, THR empty, modem change.
      if (ier[2] && (lsr & u16550_pkg::LSR_ERR_MASK) != 8'h00) begin
        iir = u16550_pkg::IIR_FIFO_BITS | u16550_pkg::IIR_LINE | IIR_PENDING;
      end else if (ier[0] && lsr[0] && (!fifo_en || count >= trig)) begin
        iir = u16550_pkg::IIR_FIFO_BITS | u16550_pkg::IIR_DATA | IIR_PENDING;
      end else if (ier[1] && lsr[5]) begin
        iir = u16550_pkg::IIR_FIFO_BITS | u16550_pkg::IIR_THRE | IIR_PENDING;
      end else if (ier[3] && (msr & u16550_pkg::MSR_DELTA_MASK) != 8'h00) begin
        iir = u16550_pkg::IIR_FIFO_BITS | u16550_pkg::IIR_MODEM | IIR_PENDING;
      end else begin
        iir = u16550_pkg::IIR_FIFO_BITS;
      end

      r.dtr_level = mcr[0];
      r.rts_level = mcr[1];
      r.irq       = iir[0];
      due_results.insert(due_results.size(), r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      end
    endfunction

    function void check_output(u16550_pkg::result_t got);
      u16550_pkg::result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $error("result beat with no pending input (read_data 0x%0h)", got.read_data);
        return;
      end
      want = due_results[0];
      due_results.delete(0);
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("access_error", 8'(want.access_error), 8'(got.access_error));
      compare_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
      compare_field("tx_byte", want.tx_byte, got.tx_byte);
      compare_field("dtr_level", 8'(want.dtr_level), 8'(got.dtr_level));
      compare_field("rts_level", 8'(want.rts_level), 8'(got.rts_level));
      compare_field("irq", 8'(want.irq), 8'(got.irq));
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] opcode;
  logic [2:0] reg_offset;
  logic [7:0] byte_in;
  logic       line_level;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] read_data;
  logic       access_error;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       dtr_level;
  logic       rts_level;
  logic       irq;

  uart_reg_scoreboard board = new();
  int unsigned        items_sent = 0;
  logic               no_idle = 1'b0;

  uart_16550_register_block u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .reg_offset   (reg_offset),
    .byte_in      (byte_in),
    .line_level   (line_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .access_error (access_error),
    .tx_valid     (tx_valid),
    .tx_byte      (tx_byte),
    .dtr_level    (dtr_level),
    .rts_level    (rts_level),
    .irq          (irq)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Both handshakes are sampled at the edge, before any new drive takes effect.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      board.add_input(opcode, reg_offset, byte_in, line_level);
    end
    if (!rst && out_valid && out_ready) begin
      board.check_output('{read_data, access_error, tx_valid, tx_byte,
                           dtr_level, rts_level, irq});
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic logic [2:0] rand_off();
    return 3'($urandom);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom);
  endfunction

  task automatic send_item(input logic [2:0] op, input logic [2:0] off,
                           input logic [7:0] data, input logic lvl);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    reg_offset <= off;
    byte_in    <= data;
    line_level <= lvl;
    do @(posedge clk); while (!in_ready);
    if (op <= u16550_pkg::OP_DSR) items_sent++;
  endtask

  // Holds the input side until every predicted result beat has been taken.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.due_results.size() != 0) @(posedge clk);
  endtask

  // Result side: random stall per beat, with ready held high across a zero stall.
  initial begin
    int unsigned stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int unsigned kind;
    int unsigned n;
    int unsigned phase_mark;
    logic [7:0]  b;
    logic [2:0]  off;
    logic [2:0]  op;

    rst        <= 1'b1;
    in_valid   <= 1'b0;
    opcode     <= u16550_pkg::OP_READ;
    reg_offset <= u16550_pkg::OFF_RBR;
    byte_in    <= 8'h00;
    line_level <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: divisor latch access, THR extremes, invalid writes, modem deltas,
    // unknown opcodes, overrun with the FIFO off, and FIFO reads down to empty.
    send_item(u16550_pkg::OP_READ, u16550_pkg::OFF_IIR, 8'h00, 1'b0);
    send_item(u16550_pkg::OP_WRITE, u16550_pkg::OFF_LCR, 8'h83, 1'b0);
    send_item(u16550_pkg::OP_WRITE, u16550_pkg::OFF_RBR, 8'hFF, 1'b0);
    send_item(u16550_pkg::OP_WRITE, u16550_pkg::OFF_IER, 8'h00, 1'b0);
    send_item(u16550_pkg::OP_READ, u16550_pkg::OFF_RBR, 8'h00, 1'b0);
    send_item(u16550_pkg::OP_READ, u16550_pkg::OFF_IER, 8'h00, 1'b0);
    send_item(u16550_pkg::OP_WRITE, u16550_pkg::OFF_LCR, 8'h03, 1'b0);
    send_item(u16550_pkg::OP_WRITE, u16550_pkg::OFF_RBR, 8'h00, 1'b0);
    send_item(u16550_pkg::OP_WRITE, u16550_pkg::OFF_RBR, 8'hFF, 1'b1);
    send_item(u16550_pkg::OP_WRITE, u16550_pkg::OFF_LSR, 8'hFF, 1'b0);
    send_item(u16550_pkg::OP_WRITE, u16550_pkg::OFF_MSR, 8'hFF, 1'b0);
    send_item(u16550_pkg::OP_WRITE, u16550_pkg::OFF_MCR, 8'hFF, 1'b0);
    send_item(u16550_pkg::OP_WRITE, u16550_pkg::OFF_IER, 8'h0F, 1'b0);
    send_item(u16550_pkg::OP_CTS, u16550_pkg::OFF_RBR, 8'h00, 1'b1);
    send_item(u16550_pkg::OP_DSR, u16550_pkg::OFF_RBR, 8'h00, 1'b1);
    send_item(u16550_pkg::OP_READ, u16550_pkg::OFF_MSR, 8'h00, 1'b0);
    send_item(OP_SPARE_LO, u16550_pkg::OFF_SCR, 8'hFF, 1'b1);
    send_item(OP_SPARE_HI, u16550_pkg::OFF_RBR, 8'h00, 1'b0);
    send_item(u16550_pkg::OP_RX_BYTE, u16550_pkg::OFF_RBR, 8'h00, 1'b0);
    send_item(u16550_pkg::OP_RX_BYTE, u16550_pkg::OFF_RBR, 8'hFF, 1'b0);
    send_item(u16550_pkg::OP_READ, u16550_pkg::OFF_LSR, 8'h00, 1'b0);
    send_item(u16550_pkg::OP_READ, u16550_pkg::OFF_RBR, 8'h00, 1'b0);
    send_item(u16550_pkg::OP_WRITE, u16550_pkg::OFF_IIR, 8'hC7, 1'b0);
    send_item(u16550_pkg::OP_RX_BYTE, u16550_pkg::OFF_RBR, 8'h5A, 1'b0);
    send_item(u16550_pkg::OP_READ, u16550_pkg::OFF_RBR, 8'h00, 1'b0);
    send_item(u16550_pkg::OP_READ, u16550_pkg::OFF_RBR, 8'h00, 1'b0);
    wait_idle();

    phase_mark = items_sent + 200;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= phase_mark) begin
        phase_mark = items_sent + 200;
        wait_idle();
        no_idle = ($urandom_range(0, 3) == 0);
      end
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1: begin
          // A burst of line bytes deep enough to hit trigger levels and overrun.
          n = $urandom_range(1, 20);
          repeat (n) send_item(u16550_pkg::OP_RX_BYTE, rand_off(), rand_byte(), rand_bit());
          n = $urandom_range(0, 18);
          repeat (n) send_item(u16550_pkg::OP_READ, u16550_pkg::OFF_RBR, rand_byte(),
                               rand_bit());
          send_item(u16550_pkg::OP_READ, u16550_pkg::OFF_LSR, rand_byte(), rand_bit());
        end
        2: begin
          send_item(u16550_pkg::OP_WRITE, u16550_pkg::OFF_LCR, rand_byte() | 8'h80,
                    rand_bit());
          send_item(u16550_pkg::OP_WRITE, u16550_pkg::OFF_RBR, rand_byte(), rand_bit());
          send_item(u16550_pkg::OP_WRITE, u16550_pkg::OFF_IER, rand_byte(), rand_bit());
          send_item(u16550_pkg::OP_READ, u16550_pkg::OFF_RBR, rand_byte(), rand_bit());
          send_item(u16550_pkg::OP_READ, u16550_pkg::OFF_IER, rand_byte(), rand_bit());
          send_item(u16550_pkg::OP_WRITE, u16550_pkg::OFF_LCR, rand_byte() & 8'h7F,
                    rand_bit());
        end
        3: begin
          b = rand_byte();
          if ($urandom_range(0, 3) != 0) b[0] = 1'b1;
          send_item(u16550_pkg::OP_WRITE, u16550_pkg::OFF_IIR, b, rand_bit());
          send_item(u16550_pkg::OP_READ, u16550_pkg::OFF_IIR, rand_byte(), rand_bit());
        end
        4: begin
          n = $urandom_range(1, 4);
          repeat (n) begin
            send_item($urandom_range(0, 1) ? u16550_pkg::OP_CTS : u16550_pkg::OP_DSR,
                      rand_off(), rand_byte(), rand_bit());
          end
          send_item(u16550_pkg::OP_READ, u16550_pkg::OFF_MSR, rand_byte(), rand_bit());
          send_item(u16550_pkg::OP_READ, u16550_pkg::OFF_IIR, rand_byte(), rand_bit());
        end
        5: begin
          send_item(u16550_pkg::OP_WRITE, u16550_pkg::OFF_IER, rand_byte(), rand_bit());
          send_item(u16550_pkg::OP_READ, u16550_pkg::OFF_IIR, rand_byte(), rand_bit());
        end
        6: begin
          off = rand_off();
          b   = rand_byte();
          if (off == u16550_pkg::OFF_LCR) b[7] = 1'b0;
          send_item(u16550_pkg::OP_WRITE, off, b, rand_bit());
        end
        default: begin
          op = ($urandom_range(0, 39) == 0)
                 ? 3'($urandom_range(int'(OP_SPARE_LO), int'(OP_SPARE_HI)))
                 : 3'($urandom_range(int'(u16550_pkg::OP_READ), int'(u16550_pkg::OP_DSR)));
          send_item(op, rand_off(), rand_byte(), rand_bit());
        end
      endcase
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+design
design/u16550_pkg.sv
design/u16550_rxq.sv
design/u16550_core.sv
design/u16550_outbuf.sv
design/uart_16550_register_block.sv
tb/tb.sv
